>>> design/lpi_pkg.sv
`timescale 1ns / 1ps

package lpi_pkg;

  // Request kinds carried on the action field.
  localparam logic [1:0] ACT_CLEAR      = 2'd0;
  localparam logic [1:0] ACT_SET_LENGTH = 2'd1;
  localparam logic [1:0] ACT_WRITE      = 2'd2;
  localparam logic [1:0] ACT_EVALUATE   = 2'd3;

  // Whole steps of a 32-bit millisecond time fit in 26 bits.
  localparam int unsigned STEP_W = 26;

  // floor(t / 100) == (t * DIV100_MAGIC) >> DIV100_SHIFT for every 32-bit t.
  localparam logic [31:0] DIV100_MAGIC = 32'h51EB_851F;
  localparam int unsigned DIV100_SHIFT = 37;

  // floor(x / 75) == (x * RECIP75) >> 30 for x below 2^22.
  localparam logic [23:0] RECIP75 = 24'd14316558;

  localparam logic [15:0] ONE_Q14 = 16'd16384;
  localparam logic [6:0]  STEP_MS = 7'd100;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_LEN,
    ST_FRAC,
    ST_MOD,
    ST_RDA,
    ST_RDB,
    ST_NUM,
    ST_SCALE,
    ST_DONE
  } state_t;

endpackage

>>> design/light_pattern_interpolator.sv
`timescale 1ns / 1ps

// Flickering-light pattern table. Each style holds a pattern length (kept in a
// small length memory) and a row of 5-bit level codes (kept in a code memory of
// min(STYLES,256)*MAX_PATTERN entries); code 12 is full brightness. A request is
// one of clear all lengths, set length, write one code, or evaluate, and every
// request gives exactly one result. Evaluate splits the time into 100 ms steps
// and a fraction, blends the codes of the current and previous step, and answers
// unsigned Q2.14 brightness (16384 is 1.0); a style of length zero or out of
// range answers 1.0. A non-evaluate request goes straight to its result. An
// evaluate reads the length and divides the time, and ends there for a
// length of zero; otherwise it works out the bit-serial remainder of the
// 26-bit step count by the pattern length, reads the two codes one after the
// other through the single code memory port, and blends and scales them in
// registered multiplies. One request is worked on at a time, and a new one is
// accepted while the previous result still waits on the output. After reset
// the code memory is zeroed one entry per cycle, min(STYLES,256) *
// MAX_PATTERN entries (16384 by default), before in_ready rises.
module light_pattern_interpolator #(
  parameter int unsigned STYLES      = 256,
  parameter int unsigned MAX_PATTERN = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_style_index,
  input  logic [5:0]  in_position,
  input  logic [4:0]  in_symbol_level,
  input  logic [6:0]  in_pattern_length,
  input  logic [31:0] in_time_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_brightness,
  output logic        out_status
);

  import lpi_pkg::*;

  // Only 256 styles can be addressed through the 8-bit style field.
  localparam int unsigned NSTY  = (STYLES < 256) ? STYLES : 256;
  localparam int unsigned SA_W  = (NSTY > 1) ? $clog2(NSTY) : 1;
  localparam int unsigned LEN_W = $clog2(MAX_PATTERN);
  localparam int unsigned CODES = NSTY * MAX_PATTERN;
  localparam int unsigned CA_W  = $clog2(CODES);

  state_t state_r, state_nxt;

  // Request fields held for the evaluate sequence.
  logic [7:0]        style_r;
  logic [31:0]       time_r;
  logic              len_vld_r;
  logic [LEN_W-1:0]  len_r;
  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] quot_r;
  logic [LEN_W-1:0]  rem_r;
  logic [LEN_W-1:0]  prev_r;
  logic [4:0]        bit_cnt_r;
  logic [6:0]        frac_r;
  logic [4:0]        a_r;
  logic [11:0]       num_r;
  logic [15:0]       res_bright_r;
  logic              res_status_r;
  logic [CA_W-1:0]   clr_cnt_r;
  logic              out_valid_r;
  logic [15:0]       out_bright_r;
  logic              out_status_r;

  // Length memory with one valid bit per style; a style that is not valid
  // reads as length zero, which is how clear all takes effect.
  logic [LEN_W-1:0] len_mem [NSTY];
  logic [NSTY-1:0]  len_vbit_r;
  logic [LEN_W-1:0] len_q_r;
  logic             len_we;

  // Code memory, one port shared by the clearing pass, writes and reads.
  logic [4:0]       code_mem [CODES];
  logic [4:0]       code_q_r;
  logic             code_we;
  logic [CA_W-1:0]  code_addr;
  logic [4:0]       code_wd;

  logic             accept;
  logic             style_ok;
  logic             pos_ok;
  logic             plen_ok;
  logic [SA_W-1:0]  in_sa;
  logic [7:0]       plen_ext;
  logic [LEN_W-1:0] len_eff;
  logic [CA_W-1:0]  in_row_base;
  logic [CA_W-1:0]  row_base;
  logic [63:0]      div_full;
  logic [LEN_W:0]   rem_shift;
  logic [LEN_W:0]   rem_diff;
  logic [45:0]      scale_full;
  logic [11:0]      num_nxt;
  logic             out_free;

  assign accept    = in_valid && in_ready;
  assign style_ok  = 32'(in_style_index) < 32'(STYLES);
  assign pos_ok    = 32'(in_position) < 32'(MAX_PATTERN);
  assign plen_ok   = 32'(in_pattern_length) < 32'(MAX_PATTERN);
  assign in_sa     = in_style_index[SA_W-1:0];
  assign plen_ext  = {1'b0, in_pattern_length};
  assign len_eff   = len_vld_r ? len_q_r : '0;
  assign out_free  = !out_valid_r || out_ready;

  assign in_row_base = CA_W'(in_style_index[SA_W-1:0]) * CA_W'(MAX_PATTERN);
  assign row_base    = CA_W'(style_r[SA_W-1:0]) * CA_W'(MAX_PATTERN);

  // Step = time / 100 through a reciprocal multiply.
  assign div_full = 64'(time_r) * 64'(DIV100_MAGIC);

  // One restoring step of the remainder of the step count by the length.
  assign rem_shift = {rem_r, quot_r[STEP_W-1]};
  assign rem_diff  = rem_shift - {1'b0, len_r};

  assign num_nxt = 12'(a_r) * 12'(frac_r) + 12'(code_q_r) * 12'(STEP_MS - frac_r);

  // Brightness = floor(num * 16384 / 1200) = floor(num * 1024 / 75).
  assign scale_full = 46'({num_r, 10'b0}) * 46'(RECIP75);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (clr_cnt_r == CA_W'(CODES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_action == ACT_EVALUATE) ? ST_LEN : ST_DONE;
        end
      end
      ST_LEN: begin
        state_nxt = (len_eff == '0) ? ST_DONE : ST_FRAC;
      end
      ST_FRAC: state_nxt = ST_MOD;
      ST_MOD: begin
        if (bit_cnt_r == 5'(STEP_W - 1)) begin
          state_nxt = ST_RDA;
        end
      end
      ST_RDA:   state_nxt = ST_RDB;
      ST_RDB:   state_nxt = ST_NUM;
      ST_NUM:   state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake and memory controls.
  always_comb begin
    in_ready  = 1'b0;
    len_we    = 1'b0;
    code_we   = 1'b0;
    code_wd   = in_symbol_level;
    code_addr = in_row_base + CA_W'(in_position);
    case (state_r)
      ST_INIT: begin
        code_we   = 1'b1;
        code_wd   = '0;
        code_addr = clr_cnt_r;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        len_we   = accept && (in_action == ACT_SET_LENGTH) && plen_ok && style_ok;
        code_we  = accept && (in_action == ACT_WRITE) && style_ok && pos_ok;
      end
      ST_RDA: code_addr = row_base + CA_W'(rem_r);
      ST_RDB: code_addr = row_base + CA_W'(prev_r);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[in_sa] <= plen_ext[LEN_W-1:0];
    end
    len_q_r <= len_mem[in_sa];
  end

  always_ff @(posedge clk) begin
    if (code_we) begin
      code_mem[code_addr] <= code_wd;
    end
    code_q_r <= code_mem[code_addr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      clr_cnt_r   <= '0;
      len_vbit_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_INIT) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (accept && (in_action == ACT_CLEAR)) begin
        len_vbit_r <= '0;
      end else if (len_we) begin
        len_vbit_r[in_sa] <= 1'b1;
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          style_r      <= in_style_index;
          time_r       <= in_time_ms;
          len_vld_r    <= style_ok && len_vbit_r[in_sa];
          res_bright_r <= '0;
          res_status_r <= (in_action == ACT_SET_LENGTH) && !plen_ok;
        end
      end
      ST_LEN: begin
        len_r        <= len_eff;
        step_r       <= div_full[DIV100_SHIFT+STEP_W-1:DIV100_SHIFT];
        res_bright_r <= ONE_Q14;
      end
      ST_FRAC: begin
        frac_r    <= time_r[6:0] - 7'(step_r[6:0] * STEP_MS);
        quot_r    <= step_r;
        rem_r     <= '0;
        bit_cnt_r <= '0;
      end
      ST_MOD: begin
        quot_r    <= {quot_r[STEP_W-2:0], 1'b0};
        bit_cnt_r <= bit_cnt_r + 5'd1;
        if (rem_shift >= {1'b0, len_r}) begin
          rem_r <= rem_diff[LEN_W-1:0];
        end else begin
          rem_r <= rem_shift[LEN_W-1:0];
        end
      end
      ST_RDA: begin
        // The previous step wraps to the last symbol.
        prev_r <= (rem_r == '0) ? (len_r - 1'b1) : (rem_r - 1'b1);
      end
      ST_RDB:   a_r          <= code_q_r;
      ST_NUM:   num_r        <= num_nxt;
      ST_SCALE: res_bright_r <= scale_full[45:30];
      ST_DONE: begin
        if (out_free) begin
          out_bright_r <= res_bright_r;
          out_status_r <= res_status_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_brightness = out_bright_r;
  assign out_status     = out_status_r;

  a_rem_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MOD) |-> (rem_r < len_r))
    else $error("remainder not below pattern length");

  a_plain_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_action != ACT_EVALUATE)) |=> (state_r == ST_DONE))
    else $error("non-evaluate request did not go straight to result");

  a_status_no_bright: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_brightness == 16'd0))
    else $error("rejected length carries brightness");

  a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_DONE))
    else $error("result shown without a finished request");

  a_bright_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_brightness <= 16'd42325))
    else $error("brightness out of range");

endmodule

>>> verif/tb_light_pattern_interpolator.sv
`timescale 1ns / 1ps

module tb_light_pattern_interpolator;
  import lpi_pkg::*;

  // The table sizes of the default build of the block.
  localparam int unsigned STYLE_COUNT   = 256;
  localparam int unsigned PATTERN_DEPTH = 64;
  // Level code that stands for full brightness.
  localparam int unsigned FULL_LEVEL    = 12;

  // Rough number of requests for the random phase.
  localparam int unsigned RANDOM_REQUESTS = 1250;
  // The limit allows for the slowest correct run, with the clearing pass
  // and the longest gaps and stalls on every request.
  localparam int unsigned CYCLE_LIMIT = 600000;
  // Settling time after the last result.
  localparam int unsigned SETTLE_CYCLES = 60;

  typedef struct packed {
    logic [15:0] brightness;
    logic        status;
  } light_result_t;

  // Keeps a private copy of the pattern table, works out the brightness that
  // each accepted request must give, and compares the results in order.
  class brightness_scoreboard;
    logic [5:0]    style_len [STYLE_COUNT];
    logic [4:0]    level_code [STYLE_COUNT * PATTERN_DEPTH];
    light_result_t awaited_q [$];
    int unsigned   mismatches;
    int unsigned   evaluations;
    int unsigned   rejected_lengths;
    int unsigned   symbol_writes;
    int unsigned   clears;

    function new();
      foreach (style_len[i]) style_len[i] = '0;
      foreach (level_code[i]) level_code[i] = '0;
      mismatches = 0;
      evaluations = 0;
      rejected_lengths = 0;
      symbol_writes = 0;
      clears = 0;
    endfunction

    function light_result_t apply_request(logic [1:0] act, logic [7:0] sty, logic [5:0] pos,
                                          logic [4:0] lvl, logic [6:0] plen,
                                          logic [31:0] t_ms);
      light_result_t    res;
      longint unsigned  len, step, frac, cur_code, prev_code, prev_pos, base, mix;
      res = '0;
      base = longint'(sty) * PATTERN_DEPTH;
      case (act)
        ACT_CLEAR: begin
          // Only the lengths go back to zero; the level codes stay.
          foreach (style_len[i]) style_len[i] = '0;
          clears++;
        end
        ACT_SET_LENGTH: begin
          if (plen >= PATTERN_DEPTH) begin
            res.status = 1'b1;
            rejected_lengths++;
          end else if (sty < STYLE_COUNT) begin
            style_len[sty] = plen[5:0];
          end
        end
        ACT_WRITE: begin
          if (sty < STYLE_COUNT && pos < PATTERN_DEPTH)
            level_code[base + pos] = lvl;
          symbol_writes++;
        end
        default: begin
          evaluations++;
          len = (sty < STYLE_COUNT) ? longint'(style_len[sty]) : 0;
          if (len == 0) begin
            res.brightness = ONE_Q14;
          end else if (len == 1) begin
            res.brightness = 16'((longint'(level_code[base]) * ONE_Q14) / FULL_LEVEL);
          end else begin
            step      = longint'(t_ms) / STEP_MS;
            frac      = longint'(t_ms) % STEP_MS;
            cur_code  = level_code[base + (step % len)];
            // Step zero blends from the last symbol of the pattern.
            prev_pos  = (step == 0) ? len - 1 : (step - 1) % len;
            prev_code = level_code[base + prev_pos];
            mix       = cur_code * frac + prev_code * (STEP_MS - frac);
            res.brightness = 16'((mix * ONE_Q14) / (FULL_LEVEL * STEP_MS));
          end
        end
      endcase
      return res;
    endfunction

    function void note_request(logic [1:0] act, logic [7:0] sty, logic [5:0] pos,
                               logic [4:0] lvl, logic [6:0] plen, logic [31:0] t_ms);
      awaited_q.push_back(apply_request(act, sty, pos, lvl, plen, t_ms));
    endfunction

    function void check_result(logic [15:0] brightness, logic status);
      light_result_t want;
      if (awaited_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result brightness=%0d status=%0d",
                 $time, brightness, status);
        return;
      end
      want = awaited_q.pop_front();
      if (brightness !== want.brightness) begin
        mismatches++;
        $display("%0t: brightness mismatch expected=%0d actual=%0d",
                 $time, want.brightness, brightness);
      end
      if (status !== want.status) begin
        mismatches++;
        $display("%0t: status mismatch expected=%0d actual=%0d",
                 $time, want.status, status);
      end
    endfunction

    function int unsigned pending();
      return awaited_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_action;
  logic [7:0]  in_style_index;
  logic [5:0]  in_position;
  logic [4:0]  in_symbol_level;
  logic [6:0]  in_pattern_length;
  logic [31:0] in_time_ms;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_brightness;
  logic        out_status;

  brightness_scoreboard sb;
  int unsigned          requests_sent;
  int unsigned          results_seen;
  int unsigned          cycle_count;
  // While set, the sender or the receiver runs without gaps for a stretch.
  logic                 send_burst;
  logic                 recv_burst;

  light_pattern_interpolator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_style_index    (in_style_index),
    .in_position       (in_position),
    .in_symbol_level   (in_symbol_level),
    .in_pattern_length (in_pattern_length),
    .in_time_ms        (in_time_ms),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_brightness    (out_brightness),
    .out_status        (out_status)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Both handshakes are observed in one process, the result first, so that a
  // request and a result taken at the same edge are handled in a fixed order.
  // Values read right after the edge are the ones that held before it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        sb.check_result(out_brightness, out_status);
        results_seen <= results_seen + 1;
      end
      if (in_valid && in_ready)
        sb.note_request(in_action, in_style_index, in_position, in_symbol_level,
                        in_pattern_length, in_time_ms);
    end
  end

  // A hung block must still end the run with a verdict.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, sb.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: before each result, out_ready stays low for a random number
  // of cycles, except during burst stretches, then it stays high until a
  // result is taken.
  initial begin
    int unsigned stall;
    out_ready <= 1'b0;
    recv_burst = 1'b0;
    forever begin
      if (results_seen % 64 == 0)
        recv_burst = ($urandom_range(0, 3) == 0);
      stall = recv_burst ? 0 : $urandom_range(0, 11);
      repeat (stall) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_valid && out_ready));
    end
  end

  // Presents one request after a random gap and holds it until it is taken.
  // A back-to-back request keeps in_valid high, so it is never lowered and
  // raised in the same step.
  task automatic send_request(logic [1:0] act, logic [7:0] sty, logic [5:0] pos,
                              logic [4:0] lvl, logic [6:0] plen, logic [31:0] t_ms);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_action         <= act;
    in_style_index    <= sty;
    in_position       <= pos;
    in_symbol_level   <= lvl;
    in_pattern_length <= plen;
    in_time_ms        <= t_ms;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  // Unused fields carry random values so that the block must ignore them.
  task automatic send_evaluate(logic [7:0] sty, logic [31:0] t_ms);
    send_request(ACT_EVALUATE, sty, 6'($urandom), 5'($urandom), 7'($urandom), t_ms);
  endtask

  task automatic send_length(logic [7:0] sty, logic [6:0] plen);
    send_request(ACT_SET_LENGTH, sty, 6'($urandom), 5'($urandom), plen, $urandom);
  endtask

  task automatic send_symbol(logic [7:0] sty, logic [5:0] pos, logic [4:0] lvl);
    send_request(ACT_WRITE, sty, pos, lvl, 7'($urandom), $urandom);
  endtask

  // Holds the sender off until every request sent so far has its result back.
  // The sender's own count is used, so a request taken at this very edge is
  // never missed.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (results_seen != requests_sent) @(posedge clk);
  endtask

  // Picks a time that lands on an interesting spot of a pattern of len steps:
  // the very first step, the edges of a step, the top of the 32-bit range,
  // a few turns around the pattern, or any 32-bit time at all.
  function automatic logic [31:0] pick_time(int unsigned len);
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 99);
      1:       return $urandom_range(0, 40000000) * 100 + ($urandom_range(0, 1) ? 99 : 0);
      2:       return 32'hFFFF_FFFF - $urandom_range(0, 300);
      3:       return $urandom_range(0, len * 300 + 299);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [4:0] pick_level();
    // Codes above 25 are legal in the field and are stored as they are.
    if ($urandom_range(0, 7) == 0) return 5'($urandom_range(26, 31));
    return 5'($urandom_range(0, 25));
  endfunction

  // Directed opening: empty styles, the length limit, one-symbol patterns,
  // wrap-around at step zero, the top of the time range, extreme codes and a
  // clear of all lengths.
  task automatic run_directed();
    send_evaluate(8'd0, 32'd0);
    send_length(8'd0, 7'd64);
    send_length(8'd255, 7'd127);
    send_length(8'd3, 7'd1);
    send_symbol(8'd3, 6'd0, 5'd12);
    send_evaluate(8'd3, 32'd12345);
    send_symbol(8'd3, 6'd0, 5'd31);
    send_evaluate(8'd3, 32'hFFFF_FFFF);
    send_length(8'd255, 7'd63);
    send_symbol(8'd255, 6'd0, 5'd25);
    send_symbol(8'd255, 6'd62, 5'd0);
    send_symbol(8'd255, 6'd63, 5'd7);
    send_evaluate(8'd255, 32'd0);
    send_evaluate(8'd255, 32'd99);
    send_evaluate(8'd255, 32'hFFFF_FFFF);
    send_length(8'd5, 7'd2);
    send_symbol(8'd5, 6'd1, 5'd31);
    send_evaluate(8'd5, 32'd150);
    send_request(ACT_CLEAR, 8'hFF, 6'h3F, 5'h1F, 7'h7F, 32'hFFFF_FFFF);
    send_evaluate(8'd255, 32'd50);
    send_length(8'd255, 7'd63);
    send_evaluate(8'd255, 32'd6250);
    send_length(8'd255, 7'd0);
    send_evaluate(8'd255, 32'd6250);
  endtask

  // One well-formed pattern: a length, a handful of symbols and a few
  // evaluations. Now and then the length is one the block must reject, in
  // which case the style keeps whatever length it had.
  task automatic run_pattern();
    logic [7:0]  sty;
    logic [6:0]  plen;
    int unsigned span;
    int unsigned writes;
    int unsigned evals;
    logic [5:0]  pos;
    sty = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
    case ($urandom_range(0, 19))
      0:       plen = 7'd0;
      1:       plen = 7'd1;
      2:       plen = 7'($urandom_range(64, 127));
      default: plen = 7'($urandom_range(2, 63));
    endcase
    send_length(sty, plen);
    span = (plen < PATTERN_DEPTH && plen > 1) ? plen : 8;
    writes = $urandom_range(1, 12);
    repeat (writes) begin
      pos = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, span - 1)) : 6'($urandom);
      send_symbol(sty, pos, pick_level());
    end
    evals = $urandom_range(1, 5);
    repeat (evals) send_evaluate(sty, pick_time(span));
  endtask

  initial begin
    int unsigned pick;
    logic        drained_midway;
    sb = new();
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_action         <= ACT_CLEAR;
    in_style_index    <= '0;
    in_position       <= '0;
    in_symbol_level   <= '0;
    in_pattern_length <= '0;
    in_time_ms        <= '0;
    requests_sent = 0;
    results_seen  = 0;
    cycle_count   = 0;
    send_burst    = 1'b0;
    drained_midway = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // The block clears its code memory before it takes the first request; the
    // sender simply waits on in_ready through that pass.
    run_directed();
    drain_results();

    while (requests_sent < RANDOM_REQUESTS) begin
      if (requests_sent % 100 < 6)
        send_burst = ($urandom_range(0, 3) == 0);
      if (!drained_midway && requests_sent >= RANDOM_REQUESTS / 2) begin
        drain_results();
        drained_midway = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 75)
        run_pattern();
      else if (pick < 96)
        send_request(2'($urandom), 8'($urandom), 6'($urandom), 5'($urandom),
                     7'($urandom), $urandom);
      else
        send_request(ACT_CLEAR, 8'($urandom), 6'($urandom), 5'($urandom),
                     7'($urandom), $urandom);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d requests: %0d evaluations, %0d symbol writes, %0d clears,",
             requests_sent, sb.evaluations, sb.symbol_writes, sb.clears);
    $display("%0d rejected lengths and %0d results checked in %0d cycles.",
             sb.rejected_lengths, results_seen, cycle_count);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> files.f
design/lpi_pkg.sv
design/light_pattern_interpolator.sv
verif/tb_light_pattern_interpolator.sv
